FILE: sv/mcw_pkg.sv
`default_nettype none
package mcw_pkg;

  localparam int TEXT_DEPTH_DEF  = 4096;
  localparam int PATTERN_MAX_DEF = 4096;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int ALPHA   = 256;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_WR,
    ST_TXT_UPD,
    ST_SH_RD,
    ST_SH_CNT,
    ST_SH_CHK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_all;
    logic restart;
    logic pat_rd;
    logic pat_wr;
    logic pat_ovf;
    logic txt_rd;
    logic txt_upd;
    logic txt_ovf;
    logic sh_rd;
    logic sh_cnt;
    logic sh_step;
    logic upd_best;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_nonzero;
    logic pat_full;
    logic txt_full;
    logic shrink_go;
    logic ws_lt_pos;
    logic surplus;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/mcw_in_if.sv
`default_nettype none
interface mcw_in_if;
  import mcw_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink (input valid, input op, input symbol, output ready);
endinterface
`default_nettype wire

FILE: sv/mcw_out_if.sv
`default_nettype none
interface mcw_out_if;
  import mcw_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] best_start;
  logic [LEN_W-1:0]   best_length;
  logic               overflow;

  modport source (output valid, output found, output best_start, output best_length,
                  output overflow, input ready);
  modport sink (input valid, input found, input best_start, input best_length,
                input overflow, output ready);
endinterface
`default_nettype wire

FILE: sv/mcw_ram.sv
`default_nettype none
module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: sv/mcw_ctrl.sv
`default_nettype none
module mcw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [mcw_pkg::OP_W-1:0]  in_op,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire mcw_pkg::dp_status_t       status,
  output mcw_pkg::dp_cmd_t               cmd
);
  import mcw_pkg::*;

  state_t state, state_next;
  logic   pending;
  logic   out_free;
  logic   accept;
  op_t    op;

  assign op       = op_t'(in_op);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && (!pending || out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_PATTERN: state_next = status.pat_full ? ST_IDLE : ST_PAT_WR;
            OP_TEXT:    state_next = status.txt_full ? ST_IDLE : ST_TXT_UPD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PAT_WR:  state_next = ST_IDLE;
      ST_TXT_UPD: state_next = status.shrink_go ? ST_SH_RD : ST_IDLE;
      ST_SH_RD:   state_next = status.ws_lt_pos ? ST_SH_CNT : ST_IDLE;
      ST_SH_CNT:  state_next = ST_SH_CHK;
      ST_SH_CHK:  state_next = status.surplus ? ST_SH_RD : ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_out = pending && out_free;
        if (accept) begin
          case (op)
            OP_CLEAR:   cmd.clear_all = 1'b1;
            OP_RESTART: cmd.restart = 1'b1;
            OP_PATTERN: begin
              cmd.restart = status.pos_nonzero;
              cmd.pat_ovf = status.pat_full;
              cmd.pat_rd  = !status.pat_full;
            end
            OP_TEXT: begin
              cmd.txt_ovf = status.txt_full;
              cmd.txt_rd  = !status.txt_full;
            end
            default: cmd.restart = 1'b1;
          endcase
        end
      end
      ST_PAT_WR:  cmd.pat_wr = 1'b1;
      ST_TXT_UPD: cmd.txt_upd = 1'b1;
      ST_SH_RD: begin
        cmd.sh_rd    = status.ws_lt_pos;
        cmd.upd_best = !status.ws_lt_pos;
      end
      ST_SH_CNT:  cmd.sh_cnt = 1'b1;
      ST_SH_CHK: begin
        cmd.sh_step  = status.surplus;
        cmd.upd_best = !status.surplus;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pending <= 1'b1;
      end else if (cmd.load_out) begin
        pending <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    accept |=> pending)
    else $error("accepted item left no pending result");

endmodule
`default_nettype wire

FILE: sv/mcw_dp.sv
`default_nettype none
module mcw_dp #(
  parameter int TEXT_DEPTH  = mcw_pkg::TEXT_DEPTH_DEF,
  parameter int PATTERN_MAX = mcw_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mcw_pkg::SYM_W-1:0]     symbol,
  input  wire mcw_pkg::dp_cmd_t              cmd,
  output mcw_pkg::dp_status_t                status,
  output logic                               out_found,
  output logic [mcw_pkg::START_W-1:0]        out_best_start,
  output logic [mcw_pkg::LEN_W-1:0]          out_best_length,
  output logic                               out_overflow
);
  import mcw_pkg::*;

  localparam int POS_W   = $clog2(TEXT_DEPTH + 1);
  localparam int ADDR_W  = $clog2(TEXT_DEPTH);
  localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CNT_MAX = (TEXT_DEPTH > PATTERN_MAX) ? TEXT_DEPTH : PATTERN_MAX;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SEL_W   = $clog2(ALPHA);

  logic [SYM_W-1:0]  sym_reg;
  logic [POS_W-1:0]  pos_reg;
  logic [POS_W-1:0]  ws_reg;
  logic [PLEN_W-1:0] plen_reg;
  logic [PLEN_W-1:0] sf_reg;
  logic [POS_W-1:0]  best_start_reg;
  logic [POS_W-1:0]  best_len_reg;
  logic              found_reg;
  logic              ovf_reg;
  logic [ALPHA-1:0]  req_vld;
  logic [ALPHA-1:0]  win_vld;
  logic              req_vld_q;
  logic              win_vld_q;

  logic [CNT_W-1:0]  req_rdata, win_rdata;
  logic [CNT_W-1:0]  req_val, win_val, win_inc;
  logic [SYM_W-1:0]  text_rdata;
  logic [SEL_W-1:0]  cnt_raddr, cnt_waddr;
  logic              cnt_re;
  logic              win_we;
  logic [CNT_W-1:0]  win_wdata;
  logic              sf_dec;
  logic [PLEN_W-1:0] sf_after;
  logic [POS_W-1:0]  win_len;
  logic              better;

  // counts read as zero until written since the last clear
  assign req_val  = req_vld_q ? req_rdata : '0;
  assign win_val  = win_vld_q ? win_rdata : '0;
  assign win_inc  = win_val + 1'b1;

  assign cnt_re    = cmd.pat_rd || cmd.txt_rd || cmd.sh_cnt;
  assign cnt_raddr = cmd.sh_cnt ? text_rdata : symbol;
  assign cnt_waddr = cmd.sh_step ? text_rdata : sym_reg;
  assign win_we    = cmd.txt_upd || cmd.sh_step;
  assign win_wdata = cmd.sh_step ? (win_val - 1'b1) : win_inc;

  assign sf_dec   = (win_inc <= req_val) && (sf_reg != '0);
  assign sf_after = sf_dec ? (sf_reg - 1'b1) : sf_reg;
  assign win_len  = pos_reg - ws_reg;
  assign better   = !found_reg || (win_len < best_len_reg);

  assign status.pos_nonzero = (pos_reg != '0);
  assign status.pat_full    = (plen_reg >= PLEN_W'(PATTERN_MAX));
  assign status.txt_full    = (pos_reg >= POS_W'(TEXT_DEPTH));
  assign status.shrink_go   = (plen_reg != '0) && (sf_after == '0);
  assign status.ws_lt_pos   = (ws_reg < pos_reg);
  assign status.surplus     = (win_val > req_val);

  mcw_ram #(.WIDTH(CNT_W), .DEPTH(ALPHA)) u_req_ram (
    .clk   (clk),
    .we    (cmd.pat_wr),
    .waddr (sym_reg),
    .wdata (req_val + 1'b1),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (req_rdata)
  );

  mcw_ram #(.WIDTH(CNT_W), .DEPTH(ALPHA)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (cnt_waddr),
    .wdata (win_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (win_rdata)
  );

  mcw_ram #(.WIDTH(SYM_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (cmd.txt_upd),
    .waddr (pos_reg[ADDR_W-1:0]),
    .wdata (sym_reg),
    .re    (cmd.sh_rd),
    .raddr (ws_reg[ADDR_W-1:0]),
    .rdata (text_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_reg        <= '0;
      ws_reg         <= '0;
      plen_reg       <= '0;
      sf_reg         <= '0;
      best_start_reg <= '0;
      best_len_reg   <= '0;
      found_reg      <= 1'b0;
      ovf_reg        <= 1'b0;
      req_vld        <= '0;
      win_vld        <= '0;
    end else begin
      if (cmd.clear_all || cmd.restart) begin
        win_vld        <= '0;
        sf_reg         <= cmd.clear_all ? '0 : plen_reg;
        pos_reg        <= '0;
        ws_reg         <= '0;
        best_start_reg <= '0;
        best_len_reg   <= '0;
        found_reg      <= 1'b0;
      end
      if (cmd.clear_all) begin
        req_vld  <= '0;
        plen_reg <= '0;
        ovf_reg  <= 1'b0;
      end
      if (cmd.pat_ovf || cmd.txt_ovf) begin
        ovf_reg <= 1'b1;
      end
      if (cmd.pat_wr) begin
        req_vld[sym_reg] <= 1'b1;
        plen_reg         <= plen_reg + 1'b1;
        sf_reg           <= sf_reg + 1'b1;
      end
      if (cmd.txt_upd) begin
        win_vld[sym_reg] <= 1'b1;
        pos_reg          <= pos_reg + 1'b1;
        sf_reg           <= sf_after;
      end
      if (cmd.sh_step) begin
        ws_reg <= ws_reg + 1'b1;
      end
      if (cmd.upd_best && better) begin
        best_start_reg <= ws_reg;
        best_len_reg   <= win_len;
        found_reg      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pat_rd || cmd.txt_rd) begin
      sym_reg <= symbol;
    end
    if (cnt_re) begin
      req_vld_q <= req_vld[cnt_raddr];
      win_vld_q <= win_vld[cnt_raddr];
    end
    if (cmd.load_out) begin
      out_found       <= found_reg;
      out_best_start  <= START_W'(best_start_reg);
      out_best_length <= LEN_W'(best_len_reg);
      out_overflow    <= ovf_reg;
    end
  end

  a_sf_le_plen: assert property (@(posedge clk) disable iff (rst)
    sf_reg <= plen_reg)
    else $error("shortfall exceeds pattern length");

  a_ws_le_pos: assert property (@(posedge clk) disable iff (rst)
    ws_reg <= pos_reg)
    else $error("window start passed text position");

  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    found_reg |-> (best_len_reg != '0) && (plen_reg != '0))
    else $error("found window is empty or pattern is empty");

endmodule
`default_nettype wire

FILE: sv/minimum_covering_window_core.sv
`default_nettype none
// Channel  Dir  Payload                                      Beat
// item     in   op[1:0], symbol[7:0]                         valid & ready
// result   out  found, best_start[11:0], best_length[12:0],  valid & ready
//               overflow
//
// Sequence: clear, restart and dropped bytes finish in the idle state; a pattern
// byte or a text byte does a count read, then a count write. Once a text byte
// closes the shortfall, the window start is trimmed byte by byte, each byte
// examined taking a text store read, a count read, then a compare and step.
// Reset: rst clears all control state; count tables clear through per-entry
// valid bits at once, so no clearing pass. Text store is never cleared.
// Stalls: one result beat is held in the output register; the next item is
// taken while it waits; the block holds off while busy or a second result is due.
module minimum_covering_window_core #(
  parameter int TEXT_DEPTH  = mcw_pkg::TEXT_DEPTH_DEF,
  parameter int PATTERN_MAX = mcw_pkg::PATTERN_MAX_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mcw_in_if.sink     item,
  mcw_out_if.source  result
);
  import mcw_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: owns the handshakes and the pending result flag.
  mcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.op),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: count tables, text store, window bookkeeping and result register.
  mcw_dp #(
    .TEXT_DEPTH  (TEXT_DEPTH),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .symbol          (item.symbol),
    .cmd             (cmd),
    .status          (status),
    .out_found       (result.found),
    .out_best_start  (result.best_start),
    .out_best_length (result.best_length),
    .out_overflow    (result.overflow)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mcw_pkg::*;

  localparam int TEXT_DEPTH  = TEXT_DEPTH_DEF;
  localparam int PATTERN_MAX = PATTERN_MAX_DEF;
  // The longest legal quiet spell is one trim across the whole text store
  // plus receiver stalls; allow several times that.
  localparam int QUIET_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 1550;

  typedef struct {
    op_t              op;
    logic [SYM_W-1:0] sym;
    bit               wait_drained;  // hold this beat until no result is owed
  } char_item_t;

  typedef struct {
    logic               found;
    logic [START_W-1:0] best_start;
    logic [LEN_W-1:0]   best_length;
    logic               overflow;
  } window_report_t;

  logic clk;
  logic rst;

  mcw_in_if  item_ch ();
  mcw_out_if result_ch ();

  minimum_covering_window_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Pending characters for the driver, and window reports still owed by the block.
  char_item_t     char_q[$];
  window_report_t report_q[$];

  int error_count;
  int items_accepted;
  int reports_seen;
  int found_reports;
  int overflow_reports;
  int widest_window;

  // ---------------------------------------------------------------------------
  // Window tracker: our own copy of the block's state at its own widths.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]   need_cnt [ALPHA];
  logic [LEN_W-1:0]   held_cnt [ALPHA];
  logic [SYM_W-1:0]   text_mem [TEXT_DEPTH];
  logic [LEN_W-1:0]   missing;
  logic [LEN_W-1:0]   pat_len;
  logic [LEN_W-1:0]   text_len;
  logic [LEN_W-1:0]   win_start;
  logic [LEN_W-1:0]   best_pos;
  logic [LEN_W-1:0]   best_len;
  logic               have_match;
  logic               dropped;

  // Forget the text but keep the pattern and the sticky overflow.
  function automatic void restart_text();
    for (int i = 0; i < ALPHA; i++) held_cnt[i] = '0;
    missing    = pat_len;
    text_len   = '0;
    win_start  = '0;
    best_pos   = '0;
    best_len   = '0;
    have_match = 1'b0;
  endfunction

  function automatic void clear_tracker();
    for (int i = 0; i < ALPHA; i++) need_cnt[i] = '0;
    pat_len = '0;
    dropped = 1'b0;
    restart_text();
  endfunction

  function automatic window_report_t track_window(op_t op, logic [SYM_W-1:0] sym);
    window_report_t   rep;
    logic [SYM_W-1:0] c;
    logic [LEN_W-1:0] span;
    bit               trimming;
    case (op)
      OP_CLEAR: begin
        clear_tracker();
      end
      OP_PATTERN: begin
        // A pattern byte arriving after text starts the text over.
        if (text_len != 0) restart_text();
        if (pat_len >= PATTERN_MAX) begin
          dropped = 1'b1;
        end else begin
          need_cnt[sym]++;
          pat_len++;
          missing++;
        end
      end
      OP_TEXT: begin
        if (text_len >= TEXT_DEPTH) begin
          dropped = 1'b1;
        end else begin
          text_mem[text_len] = sym;
          held_cnt[sym]++;
          if (held_cnt[sym] <= need_cnt[sym] && missing != 0) missing--;
          text_len++;
          if (pat_len != 0 && missing == 0) begin
            // Advance the window start past bytes that are unneeded or in surplus.
            trimming = 1'b1;
            while (trimming && win_start < text_len) begin
              c = text_mem[win_start];
              if (held_cnt[c] > need_cnt[c]) begin
                held_cnt[c]--;
                win_start++;
              end else begin
                trimming = 1'b0;
              end
            end
            span = text_len - win_start;
            // Keep the earlier window on a tie.
            if (!have_match || span < best_len) begin
              best_pos   = win_start;
              best_len   = span;
              have_match = 1'b1;
            end
          end
        end
      end
      default: begin
        restart_text();
      end
    endcase
    rep.found       = have_match;
    rep.best_start  = best_pos[START_W-1:0];
    rep.best_length = best_len;
    rep.overflow    = dropped;
    return rep;
  endfunction

  function automatic void push_char(op_t op, logic [SYM_W-1:0] sym, bit wait_drained);
    char_item_t it;
    it.op           = op;
    it.sym          = sym;
    it.wait_drained = wait_drained;
    char_q.push_back(it);
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued characters in bursts of random length with random
  // gaps. Predict each character at the edge where its beat is taken.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_chars
    char_item_t nxt;
    if (rst) begin
      item_ch.valid  <= 1'b0;
      item_ch.op     <= OP_CLEAR;
      item_ch.symbol <= '0;
      burst_left     = $urandom_range(1, 24);
      gap_left       = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        report_q.push_back(track_window(op_t'(item_ch.op), item_ch.symbol));
        items_accepted++;
        burst_left--;
        if (burst_left <= 0) begin
          // Gap of zero one time in four gives long stretches with no idling.
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      // Hold the current beat until it is taken; only then load the next one.
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          item_ch.valid <= 1'b0;
          gap_left--;
        end else if (char_q.size() == 0 ||
                     (char_q[0].wait_drained && report_q.size() != 0)) begin
          item_ch.valid <= 1'b0;
        end else begin
          nxt = char_q.pop_front();
          item_ch.valid  <= 1'b1;
          item_ch.op     <= nxt.op;
          item_ch.symbol <= nxt.sym;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result side on its own pattern and compare each result
  // beat, field by field, with the oldest owed report.
  // ---------------------------------------------------------------------------
  int          stall_mode;
  int          mode_cycles;
  logic [15:0] ready_pat;

  always @(posedge clk) begin : watch_reports
    window_report_t exp_rep;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_mode  = 0;
      mode_cycles = 0;
      ready_pat   = 16'hFFFF;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $error("result beat with no report owed: found=%0d start=%0d length=%0d",
                 result_ch.found, result_ch.best_start, result_ch.best_length);
          error_count++;
        end else begin
          exp_rep = report_q.pop_front();
          check_field("found", exp_rep.found, result_ch.found);
          check_field("best_start", exp_rep.best_start, result_ch.best_start);
          check_field("best_length", exp_rep.best_length, result_ch.best_length);
          check_field("overflow", exp_rep.overflow, result_ch.overflow);
          if (exp_rep.found) found_reports++;
          if (exp_rep.overflow) overflow_reports++;
          if (exp_rep.best_length > widest_window) widest_window = exp_rep.best_length;
        end
      end
      // Switch stall behavior when the mode counter runs out: always ready, a rotating
      // pattern, or a random three-in-four.
      mode_cycles++;
      if (mode_cycles >= 300) begin
        mode_cycles = 0;
        stall_mode  = $urandom_range(0, 2);
        ready_pat   = 16'($urandom) | 16'h0101;
      end
      ready_pat = {ready_pat[14:0], ready_pat[15]};
      case (stall_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ready_pat[0];
        default: result_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int quiet_cycles;

  always @(posedge clk) begin : watchdog
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d reports owed",
                 quiet_cycles, report_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [SYM_W-1:0] alpha [8];
    int               alpha_n;
    int               pat_n;
    int               txt_n;
    int               episode_start;
    logic [SYM_W-1:0] s;

    // Drive every input to a known value from time zero.
    item_ch.valid   = 1'b0;
    item_ch.op      = OP_CLEAR;
    item_ch.symbol  = '0;
    result_ch.ready = 1'b0;
    error_count     = 0;
    items_accepted  = 0;
    reports_seen    = 0;
    found_reports   = 0;
    overflow_reports = 0;
    widest_window   = 0;
    quiet_cycles    = 0;
    clear_tracker();
    rst = 1'b1;

    // Directed: text under an empty pattern, pattern after text, restart,
    // clear, and the extreme byte values.
    push_char(OP_TEXT, 8'h00, 1'b0);
    push_char(OP_TEXT, 8'hFF, 1'b0);
    push_char(OP_PATTERN, 8'h41, 1'b0);
    push_char(OP_PATTERN, 8'h42, 1'b0);
    push_char(OP_PATTERN, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'h00, 1'b0);
    push_char(OP_TEXT, 8'h42, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'h42, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'hAA, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_RESTART, 8'h5A, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'h42, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);
    push_char(OP_CLEAR, 8'hC3, 1'b0);
    push_char(OP_TEXT, 8'hFF, 1'b0);
    push_char(OP_PATTERN, 8'hFF, 1'b0);
    push_char(OP_PATTERN, 8'h00, 1'b0);
    push_char(OP_TEXT, 8'h00, 1'b0);
    push_char(OP_TEXT, 8'hFF, 1'b0);

    // Random: episodes of a short pattern and text over a small alphabet so
    // windows close often, salted with stray bytes and stray operations.
    episode_start = char_q.size();
    while (char_q.size() - episode_start < RANDOM_ITEMS) begin
      alpha_n = $urandom_range(2, 6);
      for (int i = 0; i < alpha_n; i++) alpha[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0)
        push_char(OP_CLEAR, 8'($urandom), $urandom_range(0, 9) == 0);
      pat_n = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 5);
      for (int i = 0; i < pat_n; i++)
        push_char(OP_PATTERN, alpha[$urandom_range(0, alpha_n - 1)], 1'b0);
      txt_n = $urandom_range(4, 50);
      for (int i = 0; i < txt_n; i++) begin
        if ($urandom_range(0, 39) == 0) begin
          push_char(OP_RESTART, 8'($urandom), 1'b0);
        end else if ($urandom_range(0, 79) == 0) begin
          push_char(op_t'($urandom_range(0, 3)), 8'($urandom), 1'b0);
        end else begin
          s = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : alpha[$urandom_range(0, alpha_n - 1)];
          push_char(OP_TEXT, s, 1'b0);
        end
      end
    end

    // Drain every owed result before the last clear goes in, then close one window.
    push_char(OP_CLEAR, 8'h00, 1'b1);
    push_char(OP_PATTERN, 8'h41, 1'b0);
    push_char(OP_TEXT, 8'h41, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every character to go in and every report to come back.
    do @(posedge clk);
    while (char_q.size() != 0 || item_ch.valid || report_q.size() != 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters, checked %0d reports (%0d with a window, %0d flagged)",
             items_accepted, reports_seen, found_reports, overflow_reports);
    $display("Short patterns over small alphabets; widest window reported: %0d",
             widest_window);
    if (error_count == 0 && report_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
